// File: src/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types, constants and helpers of the block cache directory.
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int TAG_W    = 32;
   localparam int SLOT_W   = 4;
   localparam int LAST_IDX = ENTRIES - 1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [TAG_W-1:0] tag_type;

   typedef struct packed {
      logic    operation;
      tag_type block_number;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              write_back;
      tag_type           victim_block;
      logic              fetch;
   } rsp_type;

   typedef struct packed {
      logic    en;
      idx_type idx;
      logic    dirty;
   } mark_upd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_VREAD,
      ST_VTAG,
      ST_EMIT
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_of(input idx_type idx);
      logic [SLOT_W+IDX_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// File: src/bcd_ram.sv
// ----------------------------------------------------------------------------
// bcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// File: src/bcd_marks.sv
// ----------------------------------------------------------------------------
// bcd_marks
// Valid and dirty marks of every directory entry, cleared by reset.
// ----------------------------------------------------------------------------
module bcd_marks (
   input  logic                         clock,
   input  logic                         reset,
   input  bcd_pkg::mark_upd_type        upd,
   output logic [bcd_pkg::ENTRIES-1:0]  valid_q,
   output logic [bcd_pkg::ENTRIES-1:0]  dirty_q
);
   import bcd_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [ENTRIES-1:0] dirty_ff;
   logic [ENTRIES-1:0] dirty_in;

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      if (upd.en) begin
         valid_in[upd.idx] = 1'b1;
         dirty_in[upd.idx] = upd.dirty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
      end
   end

   assign valid_q = valid_ff;
   assign dirty_q = dirty_ff;

endmodule

// File: src/bcd_ctrl.sv
// ----------------------------------------------------------------------------
// bcd_ctrl
// Request sequencer: tag scan, victim read and refill, result register.
// ----------------------------------------------------------------------------
module bcd_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bcd_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bcd_pkg::rsp_type             rsp_data,
   output logic                         rd_en,
   output bcd_pkg::idx_type             rd_addr,
   input  bcd_pkg::tag_type             rd_data,
   output logic                         wr_en,
   output bcd_pkg::idx_type             wr_addr,
   output bcd_pkg::tag_type             wr_data,
   output bcd_pkg::mark_upd_type        upd,
   input  logic [bcd_pkg::ENTRIES-1:0]  valid_q,
   input  logic [bcd_pkg::ENTRIES-1:0]  dirty_q
);
   import bcd_pkg::*;

   state_type state_ff, state_in;
   logic      op_ff, op_in;
   tag_type   blk_ff, blk_in;
   cnt_type   cnt_ff, cnt_in;
   idx_type   ptr_ff, ptr_in;
   idx_type   victim_ff, victim_in;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   idx_type   chk_idx;
   idx_type   ptr_next;
   logic      chk_match;
   logic      scan_end;
   logic      out_free;
   logic      wb;

   assign chk_idx   = cnt_ff[IDX_W-1:0] - idx_type'(1);
   assign chk_match = (cnt_ff != '0) && valid_q[chk_idx] && (rd_data == blk_ff);
   assign scan_end  = (cnt_ff == cnt_type'(ENTRIES));
   assign ptr_next  = (ptr_ff == idx_type'(LAST_IDX)) ? '0 : ptr_ff + idx_type'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign wb        = valid_q[victim_ff] && dirty_q[victim_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (chk_match) begin
               state_in = ST_EMIT;
            end else if (scan_end) begin
               state_in = ST_VREAD;
            end
         end
         ST_VREAD: state_in = ST_VTAG;
         ST_VTAG:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = victim_ff;
      wr_data      = blk_ff;
      upd          = '0;
      op_in        = op_ff;
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      victim_in    = victim_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_data.operation;
               blk_in = req_data.block_number;
               cnt_in = '0;
            end
         end
         ST_SCAN: begin
            rd_en = !scan_end;
            if (!scan_end) begin
               cnt_in = cnt_ff + cnt_type'(1);
            end
            priority if (chk_match) begin
               res_in           = '0;
               res_in.hit       = 1'b1;
               res_in.slot      = slot_of(chk_idx);
               upd.en           = (op_ff == OP_WRITE);
               upd.idx          = chk_idx;
               upd.dirty        = 1'b1;
            end else if (scan_end) begin
               ptr_in    = ptr_next;
               victim_in = ptr_next;
            end
         end
         ST_VREAD: begin
            rd_en   = 1'b1;
            rd_addr = victim_ff;
         end
         ST_VTAG: begin
            res_in.hit          = 1'b0;
            res_in.slot         = slot_of(victim_ff);
            res_in.write_back   = wb;
            res_in.victim_block = wb ? rd_data : '0;
            res_in.fetch        = (op_ff == OP_READ);
            wr_en               = 1'b1;
            upd.en              = 1'b1;
            upd.idx             = victim_ff;
            upd.dirty           = (op_ff == OP_WRITE);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      blk_ff    <= blk_in;
      cnt_ff    <= cnt_in;
      victim_ff <= victim_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/block_cache_directory.sv
// ----------------------------------------------------------------------------
// block_cache_directory
// Tag directory of a fully associative write-back block cache.
// ----------------------------------------------------------------------------
// One request at a time. Tags sit in a single-port-read RAM that is scanned
// one entry per cycle, lowest entry first; valid and dirty marks are
// flip-flops cleared by reset, so no clearing pass is needed. A hit at entry
// k ends the scan there and its response is registered from ST_EMIT; a miss
// runs the full scan, a read of the victim's old tag and the refill write
// before ST_EMIT. The next request is taken in ST_IDLE once the result has
// moved into the output register. The response sits in an output register,
// so a new request is accepted while the previous response still waits; the
// new response is then held until the waiting one is taken.
// ----------------------------------------------------------------------------
module block_cache_directory (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bcd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bcd_pkg::rsp_type  rsp_data
);
   import bcd_pkg::*;

   logic               rd_en;
   idx_type            rd_addr;
   tag_type            rd_data;
   logic               wr_en;
   idx_type            wr_addr;
   tag_type            wr_data;
   mark_upd_type       upd;
   logic [ENTRIES-1:0] valid_q;
   logic [ENTRIES-1:0] dirty_q;

   bcd_ram #(
      .WIDTH (TAG_W),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bcd_marks u_marks (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .valid_q (valid_q),
      .dirty_q (dirty_q)
   );

   bcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .upd       (upd),
      .valid_q   (valid_q),
      .dirty_q   (dirty_q)
   );

   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |->
         !rsp_data.write_back && !rsp_data.fetch && (rsp_data.victim_block == '0))
      else $error("hit response carries miss fields");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_back |-> (rsp_data.victim_block == '0))
      else $error("victim block without write-back");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

endmodule

// File: verif/block_cache_directory_checker.sv
// ----------------------------------------------------------------------------
// block_cache_directory_checker
// Watches both channels of the block cache directory, keeps its own copy of
// the tag, valid and dirty state and the round-robin pointer, works out the
// response owed for every accepted request and compares each delivered
// response with the oldest one owed, field by field.
// ----------------------------------------------------------------------------
module block_cache_directory_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bcd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bcd_pkg::rsp_type rsp_data,
   output int               fault_count,
   output int               awaited_count
);
   import bcd_pkg::*;

   tag_type     tags       [ENTRIES];
   logic        valid_mark [ENTRIES];
   logic        dirty_mark [ENTRIES];
   int unsigned refill_ptr;
   rsp_type     owed_responses [$];
   int          faults;

   function automatic rsp_type resolve_block(input req_type rq);
      rsp_type     ans;
      logic [31:0] where;
      logic        found;
      ans   = '0;
      found = 1'b0;
      where = '0;
      for (int e = 0; e < ENTRIES; e++) begin
         if (!found && valid_mark[e] && tags[e] == rq.block_number) begin
            found = 1'b1;
            where = e;
         end
      end
      if (found) begin
         if (rq.operation == OP_WRITE) begin
            dirty_mark[where] = 1'b1;
         end
      end else begin
         refill_ptr = (refill_ptr + 1) % ENTRIES;
         where      = refill_ptr;
         if (valid_mark[where] && dirty_mark[where]) begin
            ans.write_back   = 1'b1;
            ans.victim_block = tags[where];
         end
         ans.fetch         = (rq.operation == OP_READ);
         tags[where]       = rq.block_number;
         valid_mark[where] = 1'b1;
         dirty_mark[where] = (rq.operation == OP_WRITE);
      end
      ans.hit  = found;
      ans.slot = where[SLOT_W-1:0];
      return ans;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         faults++;
      end
   endtask

   initial begin
      faults        = 0;
      fault_count   = 0;
      awaited_count = 0;
   end

   always @(posedge clock) begin
      rsp_type owed;
      if (reset) begin
         for (int e = 0; e < ENTRIES; e++) begin
            tags[e]       = '0;
            valid_mark[e] = 1'b0;
            dirty_mark[e] = 1'b0;
         end
         refill_ptr = 0;
         owed_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               $error("response with no request outstanding: slot %0d, hit %0b",
                      rsp_data.slot, rsp_data.hit);
               faults++;
            end else begin
               owed = owed_responses.pop_front();
               compare_field("hit", 32'(owed.hit), 32'(rsp_data.hit));
               compare_field("slot", 32'(owed.slot), 32'(rsp_data.slot));
               compare_field("write_back", 32'(owed.write_back),
                             32'(rsp_data.write_back));
               compare_field("victim_block", owed.victim_block, rsp_data.victim_block);
               compare_field("fetch", 32'(owed.fetch), 32'(rsp_data.fetch));
            end
         end
         if (req_valid && req_ready) begin
            owed_responses.push_back(resolve_block(req_data));
         end
      end
      fault_count   <= faults;
      awaited_count <= owed_responses.size();
   end

endmodule

// File: verif/tb_block_cache_directory.sv
// ----------------------------------------------------------------------------
// tb_block_cache_directory
// Drives the block cache directory with a directed sequence covering empty,
// clean and dirty victims, hits and misses of both operations and extreme
// block numbers, then with random requests drawn mostly from a small working
// set so that hits, refills and write-backs all recur. The sender works in
// bursts, the receiver stalls on a pattern of its own and once holds off for
// a long stretch. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module tb_block_cache_directory;
   import bcd_pkg::*;

   localparam int CLK_PERIOD        = 20;
   localparam int TIMEOUT_CYCLES    = 400_000;
   localparam int RANDOM_ITEMS      = 800;
   localparam int POOL_SIZE         = 24;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int LONG_STALL_AT     = 300;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fault_count;
   int      awaited_count;
   int      burst_left = 0;
   logic    hold_off_pending = 1'b0;

   block_cache_directory DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   block_cache_directory_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fault_count   (fault_count),
      .awaited_count (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // holds valid across back-to-back requests; drops it only for a gap
   task automatic offer_request(input logic op, input tag_type blk);
      req_type item;
      int      idle_len;
      item.operation    = op;
      item.block_number = blk;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         idle_len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(0, 3);
         if (idle_len != 0) begin
            req_valid <= 1'b0;
            repeat (idle_len) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 10);
      end
   endtask

   initial begin : stimulus
      tag_type pool [POOL_SIZE];
      tag_type blk;
      logic    op;
      int      working_set;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
      pool[0] = '0;
      pool[1] = '1;
      working_set = POOL_SIZE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty victims, hits of both kinds, then wrap onto dirty and clean victims
      offer_request(OP_READ,  32'h0000_0000);
      offer_request(OP_WRITE, 32'hFFFF_FFFF);
      offer_request(OP_READ,  32'hAAAA_AAAA);
      offer_request(OP_WRITE, 32'h5555_5555);
      offer_request(OP_READ,  32'h0000_0000);
      offer_request(OP_WRITE, 32'h0000_0000);
      offer_request(OP_READ,  32'hFFFF_FFFF);
      for (int i = 1; i <= 12; i++) begin
         offer_request((i % 2) ? OP_WRITE : OP_READ, 32'h0000_1000 + i);
      end
      offer_request(OP_READ,  32'h8000_0000);
      offer_request(OP_WRITE, 32'h0000_0001);
      offer_request(OP_READ,  32'h7FFF_FFFF);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) working_set = $urandom_range(6, POOL_SIZE);
         if (n == LONG_STALL_AT) hold_off_pending = 1'b1;
         op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
         if ($urandom_range(0, 99) < 85) begin
            blk = pool[$urandom_range(0, working_set - 1)];
         end else begin
            blk = $urandom;
         end
         offer_request(op, blk);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (fault_count == 0) begin
         $display("block_cache_directory verification clean");
      end else begin
         $display("block_cache_directory verification failed");
      end
      $finish;
   end

   initial begin : receiver
      int unsigned tick;
      rx_mode_type mode;
      rsp_ready <= 1'b0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end else begin
            mode = rx_mode_type'((tick / 96) % 4);
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ((tick % 8) < 5);
            endcase
            tick++;
         end
      end
   end

   initial begin : watchdog
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("block_cache_directory verification failed");
      $finish;
   end

endmodule

// File: block_cache_directory.f
src/bcd_pkg.sv
src/bcd_ram.sv
src/bcd_marks.sv
src/bcd_ctrl.sv
src/block_cache_directory.sv
verif/block_cache_directory_checker.sv
verif/tb_block_cache_directory.sv
